// File: design/arm_alu_barrel_shifter_flags_defines.svh
// Assertion macros shared by the ALU block.
`ifndef ARM_ALU_BARREL_SHIFTER_FLAGS_DEFINES_SVH
`define ARM_ALU_BARREL_SHIFTER_FLAGS_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define AABSF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define AABSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/aabsf_pkg.sv
// Types, codes and helper functions for the ALU block.
`timescale 1ns / 1ps

package aabsf_pkg;

    localparam int W_DATA  = 32;
    localparam int FLAG_N  = 3;
    localparam int FLAG_Z  = 2;
    localparam int FLAG_C  = 1;
    localparam int FLAG_V  = 0;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
        OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
        OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
        OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
    } t_alu_op;

    typedef enum logic [3:0] {
        CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
        CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
        CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
        CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
    } t_cond;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
    } t_shift;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_UNSUP = 2'd1, ST_INVALID = 2'd2
    } t_status;

    typedef logic [3:0] t_nzcv;

    typedef struct packed {
        t_alu_op             operation;
        t_cond               condition;
        logic [W_DATA-1:0]   operand_a;
        logic [W_DATA-1:0]   operand_b;
        logic                use_immediate;
        logic [3:0]          rotate_field;
        t_shift              shift_kind;
        logic [7:0]          shift_amount;
        logic                amount_from_register;
        logic                s_bit;
    } t_in_item;

    typedef struct packed {
        logic [W_DATA-1:0]   result;
        logic                write_result;
        t_nzcv               flags_out;
        logic                executed;
        t_status             status;
    } t_out_item;

    // Second-operand request to the shifter.
    typedef struct packed {
        logic [W_DATA-1:0]   data;
        logic                use_imm;
        logic [3:0]          rot;
        t_shift              kind;
        logic [7:0]          amount;
        logic                from_reg;
        logic                carry_in;
    } t_op2_req;

    typedef struct packed {
        logic [W_DATA-1:0]   value;
        logic                carry;
    } t_op2_res;

    typedef struct packed {
        t_alu_op             op;
        logic [W_DATA-1:0]   a;
        logic [W_DATA-1:0]   b;
        logic                sh_carry;
        t_nzcv               flags;
    } t_alu_req;

    typedef struct packed {
        logic [W_DATA-1:0]   value;
        logic                c;
        logic                v;
    } t_alu_res;

    function automatic logic [W_DATA-1:0] rotr32(logic [W_DATA-1:0] x, logic [4:0] n);
        logic [2*W_DATA-1:0] t;
        t = {x, x} >> n;
        return t[W_DATA-1:0];
    endfunction

    function automatic logic cond_pass(t_cond c, t_nzcv f);
        logic n, z, cy, v, res;
        n  = f[FLAG_N];
        z  = f[FLAG_Z];
        cy = f[FLAG_C];
        v  = f[FLAG_V];
        case (c)
            CC_EQ:   res = z;
            CC_NE:   res = !z;
            CC_CS:   res = cy;
            CC_CC:   res = !cy;
            CC_MI:   res = n;
            CC_PL:   res = !n;
            CC_VS:   res = v;
            CC_VC:   res = !v;
            CC_HI:   res = cy && !z;
            CC_LS:   res = z || !cy;
            CC_GE:   res = (n == v);
            CC_LT:   res = (n != v);
            CC_GT:   res = (n == v) && !z;
            CC_LE:   res = (n != v) || z;
            default: res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

// File: design/aabsf_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
`timescale 1ns / 1ps

interface aabsf_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [3:0]  condition;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        use_immediate;
    logic [3:0]  rotate_field;
    logic [1:0]  shift_kind;
    logic [7:0]  shift_amount;
    logic        amount_from_register;
    logic        s_bit;

    modport source (
        output valid, operation, condition, operand_a, operand_b, use_immediate,
               rotate_field, shift_kind, shift_amount, amount_from_register, s_bit,
        input  ready
    );
    modport sink (
        input  valid, operation, condition, operand_a, operand_b, use_immediate,
               rotate_field, shift_kind, shift_amount, amount_from_register, s_bit,
        output ready
    );
endinterface

interface aabsf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        write_result;
    logic [3:0]  flags_out;
    logic        executed;
    logic [1:0]  status;

    modport source (
        output valid, result, write_result, flags_out, executed, status,
        input  ready
    );
    modport sink (
        input  valid, result, write_result, flags_out, executed, status,
        output ready
    );
endinterface

// File: design/aabsf_shifter.sv
// Second-operand former: rotated immediate or barrel-shifted register.
`timescale 1ns / 1ps

module aabsf_shifter (
    input  aabsf_pkg::t_op2_req i_req,
    output aabsf_pkg::t_op2_res o_res
);
    import aabsf_pkg::*;

    logic [7:0]          amt;
    logic                no_shift;
    logic                rrx;
    logic                big;
    logic                exact32;
    logic [W_DATA:0]     lsl_t;
    logic [W_DATA:0]     lsr_t;
    logic [W_DATA:0]     asr_t;
    logic [W_DATA-1:0]   ror_v;
    logic [W_DATA-1:0]   imm_v;
    logic [W_DATA-1:0]   d;

    assign d = i_req.data;

    // Decode the effective amount; immediate encodings of zero are special.
    always_comb begin
        amt      = i_req.amount;
        no_shift = 1'b0;
        rrx      = 1'b0;
        if (!i_req.from_reg) begin
            amt = {3'b000, i_req.amount[4:0]};
            if (i_req.amount[4:0] == 5'd0) begin
                case (i_req.kind)
                    SH_LSL:  no_shift = 1'b1;
                    SH_ROR:  rrx      = 1'b1;
                    default: amt      = 8'd32;
                endcase
            end
        end else if (i_req.amount == 8'd0) begin
            no_shift = 1'b1;
        end
    end

    assign big     = (amt[7:5] != 3'd0);
    assign exact32 = (amt == 8'd32);
    assign lsl_t   = {1'b0, d} << amt[4:0];
    assign lsr_t   = {d, 1'b0} >> amt[4:0];
    assign asr_t   = $signed({d, 1'b0}) >>> amt[4:0];
    assign ror_v   = rotr32(d, amt[4:0]);
    assign imm_v   = rotr32({24'd0, d[7:0]}, {i_req.rot, 1'b0});

    always_comb begin
        o_res.value = d;
        o_res.carry = i_req.carry_in;
        if (i_req.use_imm) begin
            o_res.value = imm_v;
            o_res.carry = (i_req.rot == 4'd0) ? i_req.carry_in : imm_v[W_DATA-1];
        end else if (no_shift) begin
            o_res.value = d;
        end else if (rrx) begin
            o_res.value = {i_req.carry_in, d[W_DATA-1:1]};
            o_res.carry = d[0];
        end else begin
            case (i_req.kind)
                SH_LSL: begin
                    o_res.value = big ? '0 : lsl_t[W_DATA-1:0];
                    o_res.carry = big ? (exact32 & d[0]) : lsl_t[W_DATA];
                end
                SH_LSR: begin
                    o_res.value = big ? '0 : lsr_t[W_DATA:1];
                    o_res.carry = big ? (exact32 & d[W_DATA-1]) : lsr_t[0];
                end
                SH_ASR: begin
                    o_res.value = big ? {W_DATA{d[W_DATA-1]}} : asr_t[W_DATA:1];
                    o_res.carry = big ? d[W_DATA-1] : asr_t[0];
                end
                default: begin
                    o_res.value = ror_v;
                    o_res.carry = ror_v[W_DATA-1];
                end
            endcase
        end
    end

endmodule

// File: design/aabsf_alu.sv
// Logic unit and shared 33-bit adder with carry and overflow.
`timescale 1ns / 1ps

module aabsf_alu (
    input  aabsf_pkg::t_alu_req i_req,
    output aabsf_pkg::t_alu_res o_res
);
    import aabsf_pkg::*;

    logic [W_DATA-1:0] x;
    logic [W_DATA-1:0] y;
    logic              ci;
    logic [W_DATA:0]   sum;
    logic [W_DATA-1:0] logic_v;
    logic              logical;

    // Subtracts run as x + ~y + 1 so one adder serves every arithmetic op.
    always_comb begin
        x  = i_req.a;
        y  = i_req.b;
        ci = 1'b0;
        case (i_req.op)
            OP_SUB, OP_CMP: begin
                y  = ~i_req.b;
                ci = 1'b1;
            end
            OP_RSB: begin
                x  = i_req.b;
                y  = ~i_req.a;
                ci = 1'b1;
            end
            OP_ADC:  ci = i_req.flags[FLAG_C];
            default: ci = 1'b0;
        endcase
    end

    assign sum = {1'b0, x} + {1'b0, y} + {{W_DATA{1'b0}}, ci};

    always_comb begin
        logical = 1'b1;
        case (i_req.op)
            OP_AND, OP_TST: logic_v = i_req.a & i_req.b;
            OP_EOR, OP_TEQ: logic_v = i_req.a ^ i_req.b;
            OP_ORR:         logic_v = i_req.a | i_req.b;
            OP_MOV:         logic_v = i_req.b;
            OP_BIC:         logic_v = i_req.a & ~i_req.b;
            OP_MVN:         logic_v = ~i_req.b;
            default: begin
                logic_v = i_req.b;
                logical = 1'b0;
            end
        endcase
    end

    assign o_res.value = logical ? logic_v : sum[W_DATA-1:0];
    assign o_res.c     = logical ? i_req.sh_carry : sum[W_DATA];
    assign o_res.v     = logical ? i_req.flags[FLAG_V]
                                 : ((x[W_DATA-1] ^ sum[W_DATA-1]) &
                                    (y[W_DATA-1] ^ sum[W_DATA-1]));

endmodule

// File: design/arm_alu_barrel_shifter_flags.sv
// Top level: data-processing ALU with barrel shifter and NZCV flag register.
`timescale 1ns / 1ps
`include "arm_alu_barrel_shifter_flags_defines.svh"

// One data-processing instruction per beat, one result beat per instruction.
// Throughput is one instruction per cycle while the output does not stall.
// The beat lands in an input register; condition check, shifter, ALU and
// flag logic run in one pass; the result and NZCV registers load together
// as it moves on. Since the NZCV register feeds the condition check of the
// very next instruction in the input register, dependent instructions
// issue back to back with no bubble. The input side stays ready while a
// result waits as long as the input register is empty or moving on; a
// stall on the output holds the result register, and a full input register
// is held with ready low. NV reports invalid; SBC and RSC report
// unsupported when their condition passes; in those cases and on a failed
// condition nothing is written and the flags are kept. Flags reset to zero.
module arm_alu_barrel_shifter_flags (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aabsf_in_if.sink      i_in,
    aabsf_out_if.source   o_out
);
    import aabsf_pkg::*;

    t_in_item   r_in;
    logic       r_in_vld;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       r_out_vld;
    t_nzcv      r_flags;
    t_nzcv      n_flags;

    logic       out_adv;
    logic       in_adv;
    logic       take;

    t_op2_req   sh_req;
    t_op2_res   sh_res;
    t_alu_req   alu_req;
    t_alu_res   alu_res;

    logic       is_nv;
    logic       passed;
    logic       unsup;
    logic       is_cmp;
    logic       exe;
    logic       setf;
    t_nzcv      new_flags;

    // Output register empties or drains; the input register follows it.
    assign out_adv    = !r_out_vld || o_out.ready;
    assign in_adv     = r_in_vld && out_adv;
    assign i_in.ready = !r_in_vld || out_adv;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in.operation            <= t_alu_op'(i_in.operation);
            r_in.condition            <= t_cond'(i_in.condition);
            r_in.operand_a            <= i_in.operand_a;
            r_in.operand_b            <= i_in.operand_b;
            r_in.use_immediate        <= i_in.use_immediate;
            r_in.rotate_field         <= i_in.rotate_field;
            r_in.shift_kind           <= t_shift'(i_in.shift_kind);
            r_in.shift_amount         <= i_in.shift_amount;
            r_in.amount_from_register <= i_in.amount_from_register;
            r_in.s_bit                <= i_in.s_bit;
        end
    end

    // Second operand.
    assign sh_req.data     = r_in.operand_b;
    assign sh_req.use_imm  = r_in.use_immediate;
    assign sh_req.rot      = r_in.rotate_field;
    assign sh_req.kind     = r_in.shift_kind;
    assign sh_req.amount   = r_in.shift_amount;
    assign sh_req.from_reg = r_in.amount_from_register;
    assign sh_req.carry_in = r_flags[FLAG_C];

    aabsf_shifter u_shifter (
        .i_req (sh_req),
        .o_res (sh_res)
    );

    assign alu_req.op       = r_in.operation;
    assign alu_req.a        = r_in.operand_a;
    assign alu_req.b        = sh_res.value;
    assign alu_req.sh_carry = sh_res.carry;
    assign alu_req.flags    = r_flags;

    aabsf_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // Condition check and flag update.
    assign is_nv  = (r_in.condition == CC_NV);
    assign passed = !is_nv && cond_pass(r_in.condition, r_flags);
    assign unsup  = (r_in.operation == OP_SBC) || (r_in.operation == OP_RSC);
    assign is_cmp = (r_in.operation inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
    assign exe    = passed && !unsup;
    assign setf   = exe && (r_in.s_bit || is_cmp);

    assign new_flags = {alu_res.value[W_DATA-1], (alu_res.value == '0),
                        alu_res.c, alu_res.v};
    assign n_flags   = setf ? new_flags : r_flags;

    always_comb begin
        n_out.write_result = exe && !is_cmp;
        n_out.result       = n_out.write_result ? alu_res.value : '0;
        n_out.flags_out    = n_flags;
        n_out.executed     = exe;
        if (is_nv) begin
            n_out.status = ST_INVALID;
        end else if (passed && unsup) begin
            n_out.status = ST_UNSUP;
        end else begin
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_adv) begin
                r_flags <= n_flags;
            end
            if (out_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.result       = r_out.result;
    assign o_out.write_result = r_out.write_result;
    assign o_out.flags_out    = r_out.flags_out;
    assign o_out.executed     = r_out.executed;
    assign o_out.status       = r_out.status;

    // A waiting result always carries the flags that are current.
    `AABSF_ASSERT_SAME(a_out_flags_current, r_out_vld, r_out.flags_out == r_flags, "result flags differ from flag register")
    // Flags move only when an instruction moves into the result register.
    `AABSF_ASSERT_NEXT(a_flags_hold, !in_adv, $stable(r_flags), "flags changed with no instruction retiring")
    // A write implies execution and an ok status.
    `AABSF_ASSERT_SAME(a_write_exec, r_out_vld && r_out.write_result, r_out.executed && (r_out.status == ST_OK), "write without execution")
    // Anything not executed writes nothing and returns zero.
    `AABSF_ASSERT_SAME(a_skip_clean, r_out_vld && !r_out.executed, !r_out.write_result && (r_out.result == '0), "skipped instruction left a result")

endmodule

// File: tb/sv/arm_alu_barrel_shifter_flags_tb.sv
// Self-checking testbench for the data-processing ALU with shifter and NZCV flags.
`timescale 1ns / 1ps

module arm_alu_barrel_shifter_flags_tb;
    import aabsf_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    aabsf_in_if  in_ch ();
    aabsf_out_if out_ch ();

    arm_alu_barrel_shifter_flags u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the flag register, advanced once per accepted instruction beat.
    t_nzcv     model_nzcv = '0;
    // Result beats predicted but not yet seen on the output, oldest first.
    t_out_item expected_results[$];
    int        err_count = 0;
    // When set, both sides run without idle cycles.
    logic      steady_flow = 1'b0;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    function automatic logic condition_holds(t_cond cc, t_nzcv f);
        logic n, z, cy, v;
        n  = f[FLAG_N];
        z  = f[FLAG_Z];
        cy = f[FLAG_C];
        v  = f[FLAG_V];
        case (cc)
            CC_EQ: return z;
            CC_NE: return !z;
            CC_CS: return cy;
            CC_CC: return !cy;
            CC_MI: return n;
            CC_PL: return !n;
            CC_VS: return v;
            CC_VC: return !v;
            CC_HI: return cy && !z;
            CC_LS: return z || !cy;
            CC_GE: return n == v;
            CC_LT: return n != v;
            CC_GT: return (n == v) && !z;
            CC_LE: return (n != v) || z;
            default: return 1'b1;
        endcase
    endfunction

    function automatic logic [31:0] rotate_right(logic [31:0] x, logic [4:0] n);
        if (n == 5'd0)
            return x;
        return (x >> n) | (x << (6'd32 - n));
    endfunction

    // Register operand through the barrel shifter; carry gets the shifter carry.
    function automatic logic [31:0] shift_operand(logic [31:0] d, t_shift kind,
                                                  logic [7:0] amount, logic from_reg,
                                                  logic cin, output logic carry);
        int unsigned amt;
        logic [31:0] r;
        carry = cin;
        if (!from_reg) begin
            amt = amount[4:0];
            if (amt == 0) begin
                // LSL #0 passes through, ROR #0 is RRX, LSR/ASR #0 mean 32.
                if (kind == SH_LSL)
                    return d;
                if (kind == SH_ROR) begin
                    carry = d[0];
                    return {cin, d[31:1]};
                end
                amt = 32;
            end
        end else begin
            amt = amount;
            if (amt == 0)
                return d;
        end
        case (kind)
            SH_LSL: begin
                if (amt >= 32) begin
                    carry = (amt == 32) ? d[0] : 1'b0;
                    return '0;
                end
                carry = d[32 - amt];
                return d << amt;
            end
            SH_LSR: begin
                if (amt >= 32) begin
                    carry = (amt == 32) ? d[31] : 1'b0;
                    return '0;
                end
                carry = d[amt - 1];
                return d >> amt;
            end
            SH_ASR: begin
                if (amt >= 32) begin
                    carry = d[31];
                    return {32{d[31]}};
                end
                carry = d[amt - 1];
                return $signed(d) >>> amt;
            end
            default: begin
                r = rotate_right(d, amt[4:0]);
                carry = r[31];
                return r;
            end
        endcase
    endfunction

    // Work out the result beat of one instruction and advance the shadow flags.
    function automatic t_out_item predict_alu_beat(t_in_item it);
        t_out_item   beat;
        t_nzcv       f;
        logic [31:0] a, b, n;
        logic [32:0] wide_sum;
        logic        sc, c, v, logical, setf, wr;
        f        = model_nzcv;
        beat     = '0;
        beat.status = ST_OK;
        a        = it.operand_a;
        n        = '0;
        c        = f[FLAG_C];
        v        = f[FLAG_V];
        logical  = 1'b0;
        setf     = it.s_bit;
        wr       = 1'b1;
        if (it.condition == CC_NV) begin
            beat.status = ST_INVALID;
        end else if (condition_holds(it.condition, f)) begin
            if (it.operation == OP_SBC || it.operation == OP_RSC) begin
                beat.status = ST_UNSUP;
            end else begin
                if (it.use_immediate) begin
                    b  = rotate_right({24'd0, it.operand_b[7:0]}, {it.rotate_field, 1'b0});
                    sc = (it.rotate_field == 4'd0) ? f[FLAG_C] : b[31];
                end else begin
                    b = shift_operand(it.operand_b, it.shift_kind, it.shift_amount,
                                      it.amount_from_register, f[FLAG_C], sc);
                end
                case (it.operation)
                    OP_AND, OP_TST: begin n = a & b;  logical = 1'b1; end
                    OP_EOR, OP_TEQ: begin n = a ^ b;  logical = 1'b1; end
                    OP_ORR:         begin n = a | b;  logical = 1'b1; end
                    OP_MOV:         begin n = b;      logical = 1'b1; end
                    OP_BIC:         begin n = a & ~b; logical = 1'b1; end
                    OP_MVN:         begin n = ~b;     logical = 1'b1; end
                    OP_SUB, OP_CMP: begin
                        n = a - b;
                        c = (a >= b);
                        v = (a[31] ^ b[31]) & (a[31] ^ n[31]);
                    end
                    OP_RSB: begin
                        n = b - a;
                        c = (b >= a);
                        v = (b[31] ^ a[31]) & (b[31] ^ n[31]);
                    end
                    OP_ADD, OP_CMN: begin
                        n = a + b;
                        c = (n < a);
                        v = (a[31] ^ n[31]) & (b[31] ^ n[31]);
                    end
                    default: begin
                        // ADC: carry out of the full 33-bit sum, overflow of the whole sum.
                        wide_sum = {1'b0, a} + {1'b0, b} + {32'd0, f[FLAG_C]};
                        n = wide_sum[31:0];
                        c = wide_sum[32];
                        v = (a[31] ^ n[31]) & (b[31] ^ n[31]);
                    end
                endcase
                if (it.operation == OP_TST || it.operation == OP_TEQ ||
                    it.operation == OP_CMP || it.operation == OP_CMN) begin
                    wr   = 1'b0;
                    setf = 1'b1;
                end
                if (logical)
                    c = sc;
                if (setf)
                    model_nzcv = {n[31], n == 32'd0, c, v};
                beat.executed     = 1'b1;
                beat.write_result = wr;
                beat.result       = wr ? n : 32'd0;
            end
        end
        beat.flags_out = model_nzcv;
        return beat;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic t_in_item make_instr(t_alu_op op, t_cond cc, logic [31:0] a,
                                            logic [31:0] b, logic imm, logic [3:0] rot,
                                            t_shift kind, logic [7:0] amt,
                                            logic from_reg, logic s);
        t_in_item it;
        it.operation            = op;
        it.condition            = cc;
        it.operand_a            = a;
        it.operand_b            = b;
        it.use_immediate        = imm;
        it.rotate_field         = rot;
        it.shift_kind           = kind;
        it.shift_amount         = amt;
        it.amount_from_register = from_reg;
        it.s_bit                = s;
        return it;
    endfunction

    // Bias operands toward the corners of the adder and the shifter.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_amount();
        case ($urandom_range(0, 11))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd31;
            3: return 8'd32;
            4: return 8'd33;
            5: return 8'd64;
            6: return 8'd255;
            7, 8: return 8'($urandom_range(0, 31));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_instr();
        t_in_item it;
        it.operation = t_alu_op'($urandom_range(0, 15));
        // Biased toward AL so the ALU path is reached; the rest exercises every condition.
        it.condition = ($urandom_range(0, 9) < 4) ? CC_AL : t_cond'($urandom_range(0, 15));
        it.operand_a            = pick_word();
        it.operand_b            = pick_word();
        it.use_immediate        = 1'($urandom_range(0, 1));
        it.rotate_field         = 4'($urandom_range(0, 15));
        it.shift_kind           = t_shift'($urandom_range(0, 3));
        it.shift_amount         = pick_amount();
        it.amount_from_register = 1'($urandom_range(0, 1));
        it.s_bit                = ($urandom_range(0, 9) < 7);
        return it;
    endfunction

    // Drive one instruction beat at the falling edge, hold until accepted, then predict.
    task automatic send_instr(input t_in_item it);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid                <= 1'b1;
        in_ch.operation            <= it.operation;
        in_ch.condition            <= it.condition;
        in_ch.operand_a            <= it.operand_a;
        in_ch.operand_b            <= it.operand_b;
        in_ch.use_immediate        <= it.use_immediate;
        in_ch.rotate_field         <= it.rotate_field;
        in_ch.shift_kind           <= it.shift_kind;
        in_ch.shift_amount         <= it.shift_amount;
        in_ch.amount_from_register <= it.amount_from_register;
        in_ch.s_bit                <= it.s_bit;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_results.push_back(predict_alu_beat(it));
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Every opcode once with flag setting on; SBC and RSC come back unsupported.
    task automatic test_operation_sweep();
        for (int i = 0; i < 16; i++)
            send_instr(make_instr(t_alu_op'(i), CC_AL, 32'h7FFF_FFFF,
                                  32'h8000_0001 ^ i, 1'b0, 4'd0, SH_LSL, 8'd0, 1'b0, 1'b1));
    endtask

    // Set Z with a compare, then fail NE, then try NV.
    task automatic test_condition_cases();
        send_instr(make_instr(OP_CMP, CC_AL, 32'd5, 32'd5, 1'b0, 4'd0, SH_LSL, 8'd0,
                              1'b0, 1'b0));
        send_instr(make_instr(OP_MOV, CC_NE, 32'd0, 32'h1234_5678, 1'b0, 4'd0, SH_LSL,
                              8'd0, 1'b0, 1'b1));
        send_instr(make_instr(OP_ADD, CC_NV, 32'd1, 32'd1, 1'b0, 4'd0, SH_LSL, 8'd0,
                              1'b0, 1'b1));
    endtask

    // Immediate rotates and the shifter's zero and 32-or-more corners, all through MOVS.
    task automatic test_shifter_edges();
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'hFFFF_FF80, 1'b1, 4'd0, SH_LSL,
                              8'd0, 1'b0, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'hFFFF_FFFF, 1'b1, 4'd15, SH_ROR,
                              8'hFF, 1'b1, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'h8000_0001, 1'b0, 4'd0, SH_LSL,
                              8'hE0, 1'b0, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'h8000_0000, 1'b0, 4'd0, SH_LSR,
                              8'd0, 1'b0, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'h8000_0001, 1'b0, 4'd0, SH_ASR,
                              8'd0, 1'b0, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'h0000_0001, 1'b0, 4'd0, SH_ROR,
                              8'd0, 1'b0, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'h0000_0001, 1'b0, 4'd0, SH_LSL,
                              8'd32, 1'b1, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'hFFFF_FFFF, 1'b0, 4'd0, SH_LSR,
                              8'd33, 1'b1, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'h8000_0000, 1'b0, 4'd0, SH_ASR,
                              8'd255, 1'b1, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'h8765_4321, 1'b0, 4'd0, SH_ROR,
                              8'd64, 1'b1, 1'b1));
        send_instr(make_instr(OP_MOV, CC_AL, 32'd0, 32'h0F0F_0F0F, 1'b0, 4'd0, SH_LSR,
                              8'd0, 1'b1, 1'b1));
    endtask

    // ADC with carry in: wrap to zero with carry out, then signed overflow.
    task automatic test_adc_carry();
        send_instr(make_instr(OP_CMP, CC_AL, 32'd0, 32'd0, 1'b0, 4'd0, SH_LSL, 8'd0,
                              1'b0, 1'b0));
        send_instr(make_instr(OP_ADC, CC_AL, 32'hFFFF_FFFF, 32'd0, 1'b0, 4'd0, SH_LSL,
                              8'd0, 1'b0, 1'b1));
        send_instr(make_instr(OP_ADC, CC_AL, 32'h7FFF_FFFF, 32'd0, 1'b0, 4'd0, SH_LSL,
                              8'd0, 1'b0, 1'b1));
    endtask

    // Random instructions; every hundred beats pick idling or steady flow at random.
    task automatic test_random_mix(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 100 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            send_instr(random_instr());
        end
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------------

    function automatic void compare_field(string name, logic [31:0] exp_val,
                                          logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_val, got_val);
            err_count++;
        end
    endfunction

    // Accept result beats with random stalls and compare each with the oldest prediction.
    initial begin
        int unsigned gap;
        t_out_item   want;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = steady_flow ? 0 : $urandom_range(0, 10);
            @(negedge i_clk);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (expected_results.size() == 0) begin
                $error("result beat with no prediction waiting: result %h",
                       out_ch.result);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("result", want.result, out_ch.result);
                compare_field("write_result", 32'(want.write_result),
                              32'(out_ch.write_result));
                compare_field("flags_out", 32'(want.flags_out), 32'(out_ch.flags_out));
                compare_field("executed", 32'(want.executed), 32'(out_ch.executed));
                compare_field("status", 32'(want.status), 32'(out_ch.status));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial begin
        // Drive every input to a known value before reset drops.
        in_ch.valid                = 1'b0;
        in_ch.operation            = '0;
        in_ch.condition            = '0;
        in_ch.operand_a            = '0;
        in_ch.operand_b            = '0;
        in_ch.use_immediate        = 1'b0;
        in_ch.rotate_field         = '0;
        in_ch.shift_kind           = '0;
        in_ch.shift_amount         = '0;
        in_ch.amount_from_register = 1'b0;
        in_ch.s_bit                = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_operation_sweep();
        test_condition_cases();
        test_shifter_edges();
        test_adc_carry();
        test_random_mix(850);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        // Drain the remaining result beats, then watch for stray ones.
        wait (expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
